/* rtl/rrts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MaxThreadsDef = 16;
  localparam int TidOutW       = 4;
  localparam int WordW         = 32;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CREATE   = 2'd1,
    OP_SLEEP    = 2'd2,
    OP_WAKE     = 2'd3
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic fetch;
    logic emit;
  } rrts_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    op_e  op;
    logic scan_done;
    logic out_busy;
  } rrts_sts_t;

endpackage
`default_nettype wire

/* rtl/round_robin_thread_scheduler_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an item is accepted and executed; a schedule then scans k threads (at
// most the thread count) and fetches the chosen one. The result goes to the output register.
// A new item is taken only once the last result is in the output register;
// the scan reads one wake deadline per cycle from the single-port table.
// Reset: one thread (thread 0) with zero pc, sp and deadline; no item pending.
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Thread scheduler with round-robin choice among threads whose deadline passed.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core import rrts_pkg::*; #(
  parameter int MaxThreads = MaxThreadsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [WordW-1:0]   now_ms_i,
  input  wire logic [WordW-1:0]   pc_value_i,
  input  wire logic [WordW-1:0]   sp_value_i,
  input  wire logic [WordW-1:0]   delay_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [TidOutW-1:0]      thread_id_o,
  output logic [WordW-1:0]        next_pc_o,
  output logic [WordW-1:0]        next_sp_o,
  output logic                    table_full_o
);

  rrts_cmd_t cmd;
  rrts_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrts_datapath #(
    .MaxThreads (MaxThreads)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (op_i),
    .now_ms_i     (now_ms_i),
    .pc_value_i   (pc_value_i),
    .sp_value_i   (sp_value_i),
    .delay_ms_i   (delay_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .thread_id_o  (thread_id_o),
    .next_pc_o    (next_pc_o),
    .next_sp_o    (next_sp_o),
    .table_full_o (table_full_o)
  );

endmodule
`default_nettype wire

/* rtl/rrts_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencing state machine: accept, execute, scan, fetch, deliver.
// ----------------------------------------------------------------------------
module rrts_ctrl import rrts_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rrts_sts_t sts_i,
  output rrts_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = (sts_i.op == OP_SCHEDULE) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/rrts_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_datapath
// Thread table memories, scan pointer, current thread and output register.
// ----------------------------------------------------------------------------
module rrts_datapath import rrts_pkg::*; #(
  parameter int MaxThreads = MaxThreadsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rrts_cmd_t          cmd_i,
  output rrts_sts_t               sts_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [WordW-1:0]   now_ms_i,
  input  wire logic [WordW-1:0]   pc_value_i,
  input  wire logic [WordW-1:0]   sp_value_i,
  input  wire logic [WordW-1:0]   delay_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [TidOutW-1:0]      thread_id_o,
  output logic [WordW-1:0]        next_pc_o,
  output logic [WordW-1:0]        next_sp_o,
  output logic                    table_full_o
);

  localparam int TidW = $clog2(MaxThreads);
  localparam int CntW = $clog2(MaxThreads + 1);

  // thread table
  logic [WordW-1:0] mem_dl [MaxThreads];
  logic [WordW-1:0] mem_pc [MaxThreads];
  logic [WordW-1:0] mem_sp [MaxThreads];

  // captured item
  op_e              op_q;
  logic [WordW-1:0] now_q, pc_q, sp_q, delay_q;

  logic [CntW-1:0]  count_q, count_d;
  logic [TidW-1:0]  cur_q, cur_d;
  logic [TidW-1:0]  sel_q, sel_d;
  logic [TidW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]  issued_q, issued_d;
  logic             pend_q, pend_d;
  logic             full_q, full_d;
  logic             pc0_wr_q, dl0_wr_q;

  logic [TidW-1:0]  rd_idx_q;
  logic [WordW-1:0] rd_dl_q, rd_pc_q, rd_sp_q;
  logic             rd_dlz_q, rd_pcz_q;

  logic             out_valid_q, out_valid_d;
  logic [TidOutW-1:0] tid_q;
  logic [WordW-1:0] npc_q, nsp_q;
  logic             tf_q;

  logic             full;
  logic [TidW-1:0]  slot;
  logic [TidW-1:0]  wr_addr;
  logic             pcsp_we, dl_we;
  logic [WordW-1:0] dl_wdata;
  logic [CntW-1:0]  cur_inc, ptr_inc;
  logic [TidW-1:0]  cur_next, ptr_next;
  logic             issue, hit;
  logic [WordW-1:0] dl_val;
  logic [TidW+TidOutW-1:0] id_ext;

  assign full = (count_q == CntW'(MaxThreads));
  assign slot = count_q[TidW-1:0];

  // round-robin successors, wrapping at the thread count
  assign cur_inc  = CntW'(cur_q) + CntW'(1);
  assign cur_next = (cur_inc >= count_q) ? '0 : cur_inc[TidW-1:0];
  assign ptr_inc  = CntW'(ptr_q) + CntW'(1);
  assign ptr_next = (ptr_inc >= count_q) ? '0 : ptr_inc[TidW-1:0];

  assign wr_addr  = (op_q == OP_CREATE) ? slot : cur_q;
  assign pcsp_we  = cmd_i.exec &&
                    ((op_q == OP_SCHEDULE) || ((op_q == OP_CREATE) && !full));
  assign dl_we    = cmd_i.exec && (op_q != OP_SCHEDULE) &&
                    !((op_q == OP_CREATE) && full);
  assign dl_wdata = (op_q == OP_SLEEP) ? (now_q + delay_q) : '0;

  assign issue  = cmd_i.scan && (issued_q != count_q);
  assign dl_val = rd_dlz_q ? '0 : rd_dl_q;
  assign hit    = cmd_i.scan && pend_q && (dl_val <= now_q);

  assign id_ext = {{TidOutW{1'b0}}, sel_q};

  always_comb begin
    count_d  = count_q;
    cur_d    = cur_q;
    sel_d    = sel_q;
    ptr_d    = ptr_q;
    issued_d = issued_q;
    pend_d   = pend_q;
    full_d   = full_q;
    if (cmd_i.exec) begin
      ptr_d    = cur_next;
      issued_d = '0;
      pend_d   = 1'b0;
      full_d   = (op_q == OP_CREATE) && full;
      sel_d    = ((op_q == OP_CREATE) && !full) ? slot : cur_q;
      if ((op_q == OP_CREATE) && !full) begin
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.scan) begin
      pend_d = issue;
      sel_d  = hit ? rd_idx_q : cur_q;
      if (issue) begin
        ptr_d    = ptr_next;
        issued_d = issued_q + CntW'(1);
      end
    end
    if (cmd_i.fetch) begin
      cur_d = sel_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CntW'(1);
      cur_q       <= '0;
      sel_q       <= '0;
      ptr_q       <= '0;
      issued_q    <= '0;
      pend_q      <= 1'b0;
      full_q      <= 1'b0;
      pc0_wr_q    <= 1'b0;
      dl0_wr_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cur_q       <= cur_d;
      sel_q       <= sel_d;
      ptr_q       <= ptr_d;
      issued_q    <= issued_d;
      pend_q      <= pend_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      // entry 0 reads as zero until it is first written
      if (pcsp_we && (wr_addr == '0)) begin
        pc0_wr_q <= 1'b1;
      end
      if (dl_we && (wr_addr == '0)) begin
        dl0_wr_q <= 1'b1;
      end
    end
  end

  // captured item and memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      now_q   <= now_ms_i;
      pc_q    <= pc_value_i;
      sp_q    <= sp_value_i;
      delay_q <= delay_ms_i;
    end
    if (pcsp_we) begin
      mem_pc[wr_addr] <= pc_q;
      mem_sp[wr_addr] <= sp_q;
    end
    if (dl_we) begin
      mem_dl[wr_addr] <= dl_wdata;
    end
    if (issue) begin
      rd_dl_q  <= mem_dl[ptr_q];
      rd_dlz_q <= (ptr_q == '0) && !dl0_wr_q;
      rd_idx_q <= ptr_q;
    end
    if (cmd_i.fetch) begin
      rd_pc_q  <= mem_pc[sel_q];
      rd_sp_q  <= mem_sp[sel_q];
      rd_pcz_q <= (sel_q == '0) && !pc0_wr_q;
    end
    if (cmd_i.emit) begin
      tid_q <= id_ext[TidOutW-1:0];
      tf_q  <= full_q;
      if ((op_q == OP_SCHEDULE) && !rd_pcz_q) begin
        npc_q <= rd_pc_q;
        nsp_q <= rd_sp_q;
      end else begin
        npc_q <= '0;
        nsp_q <= '0;
      end
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.scan_done = hit || (issued_q == count_q);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign thread_id_o  = tid_q;
  assign next_pc_o    = npc_q;
  assign next_sp_o    = nsp_q;
  assign table_full_o = tf_q;

  a_cur_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(cur_q) < count_q)
    else $error("current thread outside the table");

  a_sel_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(sel_q) < count_q)
    else $error("selected thread outside the table");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CntW'(MaxThreads)))
    else $error("thread count out of range");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("result written over an item not yet taken");

endmodule
`default_nettype wire
